@@ design/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// owm_pkg
// shared types and codes of the single-wire bus master
// ----------------------------------------------------------------------------
package owm_pkg;

   localparam int SCRATCH_BYTES = 9;
   localparam int TIMER_BITS    = 10;
   localparam int QUEUE_DEPTH   = 2;

   // command codes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_RESET   = 3'd1;
   localparam logic [2:0] OP_WRITE   = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_CONVERT = 3'd4;
   localparam logic [2:0] OP_SCRATCH = 3'd5;
   localparam logic [2:0] OP_PULLUP  = 3'd6;
   localparam logic [2:0] OP_UNUSED  = 3'd7;

   // word classes chosen by the front end
   localparam logic [1:0] CLS_TICK   = 2'd0;
   localparam logic [1:0] CLS_CMD    = 2'd1;
   localparam logic [1:0] CLS_PULLUP = 2'd2;
   localparam logic [1:0] CLS_NOP    = 2'd3;

   // event and status codes
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_DONE = 2'd1;
   localparam logic [1:0] EV_BYTE = 2'd2;
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_DEV  = 2'd1;
   localparam logic [1:0] ST_BUSY    = 2'd2;

   // register indexes
   localparam logic [2:0] REG_RESET_LOW  = 3'd0;
   localparam logic [2:0] REG_PRES_WAIT  = 3'd1;
   localparam logic [2:0] REG_RESET_REC  = 3'd2;
   localparam logic [2:0] REG_SLOT_SHORT = 3'd3;
   localparam logic [2:0] REG_SLOT_LONG  = 3'd4;

   // bus command bytes
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_SP  = 8'hBE;

   typedef struct packed {
      logic [9:0] reset_low_ticks;
      logic [9:0] presence_wait_ticks;
      logic [9:0] reset_recovery_ticks;
      logic [7:0] slot_short_ticks;
      logic [7:0] slot_long_ticks;
   } owm_cfg_type;

   typedef struct packed {
      logic [1:0] cls;
      logic [2:0] op;
      logic [7:0] data;
      logic       line_level;
   } owm_cmd_type;

   typedef struct packed {
      logic       drive_low;
      logic       drive_high;
      logic [1:0] event_res;
      logic [1:0] status;
      logic [7:0] read_data;
      logic       last;
      logic       busy_res;
   } owm_rsp_type;

endpackage

@@ design/owm_front.sv @@
// ----------------------------------------------------------------------------
// owm_front
// accepts input words, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module owm_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [2:0]           op,
   input  logic [7:0]           data,
   input  logic                 line_level,
   output logic                 cmd_valid,
   output owm_pkg::owm_cmd_type cmd,
   input  logic                 cmd_take
);
   import owm_pkg::*;

   owm_cmd_type entry_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   owm_cmd_type word;
   logic        push_ok;

   always_comb begin
      word.op         = op;
      word.data       = data;
      word.line_level = line_level;
      unique case (op)
         OP_TICK:   word.cls = CLS_TICK;
         OP_PULLUP: word.cls = CLS_PULLUP;
         OP_UNUSED: word.cls = CLS_NOP;
         default:   word.cls = CLS_CMD;
      endcase
   end

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign push_ok   = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ cmd_take;
      count_in  = count_ff + 2'(push_ok) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/owm_engine.sv @@
// ----------------------------------------------------------------------------
// owm_engine
// bus timing state machine, one queued word per step
// ----------------------------------------------------------------------------
module owm_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  owm_pkg::owm_cfg_type cfg,
   input  logic                 cmd_valid,
   input  owm_pkg::owm_cmd_type cmd,
   output logic                 cmd_take,
   input  logic                 rsp_full,
   output owm_pkg::owm_rsp_type rsp
);
   import owm_pkg::*;

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_REC  = 4'd3;
   localparam logic [3:0] PH_WR_LOW   = 4'd4;
   localparam logic [3:0] PH_WR_REL   = 4'd5;
   localparam logic [3:0] PH_RD_LOW   = 4'd6;
   localparam logic [3:0] PH_RD_WAIT  = 4'd7;
   localparam logic [3:0] PH_RD_REC   = 4'd8;

   localparam logic [15:0] TMAX = 16'((1 << TIMER_BITS) - 1);

   // phase length: zero counts as one tick, saturate to the timer range
   function automatic logic [TIMER_BITS-1:0] load_ticks(input logic [9:0] v);
      logic [15:0] w;
      w = 16'(v);
      if (w > TMAX) w = TMAX;
      if (w == 16'd0) w = 16'd1;
      return TIMER_BITS'(w);
   endfunction

   logic [3:0]            phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in, timer_dec;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in, shift_next;
   logic [3:0]            bcount_ff, bcount_in, bcount_inc;
   logic [2:0]            seq_ff, seq_in;
   logic [2:0]            active_ff, active_in;
   logic                  spu_ff, spu_in;

   logic       busy;
   logic       start_wr, start_rd, do_finish;
   logic [7:0] wr_byte;
   logic [1:0] fin_ev, fin_st, ev, st;
   logic [7:0] rdat;
   logic       rlast;

   assign cmd_take   = cmd_valid && !rsp_full;
   assign busy       = (phase_ff != PH_IDLE);
   assign timer_dec  = timer_ff - 1'b1;
   assign shift_next = {1'b0, shift_ff[7:1]};
   assign bcount_inc = bcount_ff + 4'd1;

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      bcount_in = bcount_ff;
      seq_in    = seq_ff;
      active_in = active_ff;
      spu_in    = spu_ff;
      start_wr  = 1'b0;
      start_rd  = 1'b0;
      do_finish = 1'b0;
      wr_byte   = 8'd0;
      fin_ev    = EV_NONE;
      fin_st    = ST_OK;
      ev        = EV_NONE;
      st        = ST_OK;
      rdat      = 8'd0;
      rlast     = 1'b0;

      if (cmd.cls == CLS_NOP) begin
         // unused code: no effect
      end else if (busy) begin
         if (cmd.cls == CLS_TICK) begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               unique case (phase_ff)
                  PH_RST_LOW: begin
                     phase_in = PH_RST_WAIT;
                     timer_in = load_ticks(cfg.presence_wait_ticks);
                  end
                  PH_RST_WAIT: begin
                     // presence pulse: line low means a device answered
                     shift_in = {7'd0, !cmd.line_level};
                     phase_in = PH_RST_REC;
                     timer_in = load_ticks(cfg.reset_recovery_ticks);
                  end
                  PH_RST_REC: begin
                     if (!shift_ff[0]) begin
                        do_finish = 1'b1;
                        fin_ev    = EV_DONE;
                        fin_st    = ST_NO_DEV;
                     end else if (active_ff == OP_RESET) begin
                        do_finish = 1'b1;
                        fin_ev    = EV_DONE;
                     end else begin
                        seq_in   = 3'd1;
                        start_wr = 1'b1;
                        wr_byte  = CMD_SKIP_ROM;
                     end
                  end
                  PH_WR_LOW: begin
                     phase_in = PH_WR_REL;
                     timer_in = shift_ff[0] ? load_ticks({2'b0, cfg.slot_long_ticks})
                                            : load_ticks({2'b0, cfg.slot_short_ticks});
                  end
                  PH_WR_REL: begin
                     shift_in = shift_next;
                     if (bit_ff == 3'd7) begin
                        if ((active_ff == OP_CONVERT || active_ff == OP_SCRATCH)
                            && seq_ff == 3'd1) begin
                           seq_in   = 3'd2;
                           start_wr = 1'b1;
                           wr_byte  = (active_ff == OP_CONVERT) ? CMD_CONVERT : CMD_READ_SP;
                        end else if (active_ff == OP_SCRATCH) begin
                           seq_in    = 3'd3;
                           bcount_in = 4'd0;
                           start_rd  = 1'b1;
                        end else begin
                           do_finish = 1'b1;
                           fin_ev    = EV_DONE;
                        end
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = PH_WR_LOW;
                        timer_in = shift_next[0] ? load_ticks({2'b0, cfg.slot_short_ticks})
                                                 : load_ticks({2'b0, cfg.slot_long_ticks});
                     end
                  end
                  PH_RD_LOW: begin
                     phase_in = PH_RD_WAIT;
                     timer_in = load_ticks({2'b0, cfg.slot_short_ticks});
                  end
                  PH_RD_WAIT: begin
                     shift_in = {cmd.line_level, shift_ff[7:1]};
                     phase_in = PH_RD_REC;
                     timer_in = load_ticks({2'b0, cfg.slot_long_ticks});
                  end
                  PH_RD_REC: begin
                     if (bit_ff == 3'd7) begin
                        rdat = shift_ff;
                        if (active_ff == OP_SCRATCH) begin
                           bcount_in = bcount_inc;
                        end
                        if (active_ff == OP_SCRATCH && bcount_inc < 4'(SCRATCH_BYTES)) begin
                           start_rd = 1'b1;
                           ev       = EV_BYTE;
                        end else begin
                           do_finish = 1'b1;
                           fin_ev    = EV_BYTE;
                           rlast     = 1'b1;
                        end
                     end else begin
                        bit_in   = bit_ff + 3'd1;
                        phase_in = PH_RD_LOW;
                        timer_in = load_ticks({2'b0, cfg.slot_short_ticks});
                     end
                  end
                  default: begin
                     do_finish = 1'b1;
                  end
               endcase
            end
         end else begin
            st = ST_BUSY;
         end
      end else if (cmd.cls == CLS_PULLUP) begin
         spu_in = cmd.data[0];
         ev     = EV_DONE;
      end else if (cmd.cls == CLS_CMD) begin
         spu_in    = 1'b0;
         active_in = cmd.op;
         seq_in    = 3'd0;
         priority case (cmd.op)
            OP_WRITE: begin
               start_wr = 1'b1;
               wr_byte  = cmd.data;
            end
            OP_READ: begin
               start_rd = 1'b1;
            end
            default: begin
               if (!cmd.line_level) begin
                  do_finish = 1'b1;
                  fin_ev    = EV_DONE;
                  fin_st    = ST_NO_DEV;
               end else begin
                  phase_in = PH_RST_LOW;
                  timer_in = load_ticks(cfg.reset_low_ticks);
               end
            end
         endcase
      end

      if (start_wr) begin
         shift_in = wr_byte;
         bit_in   = 3'd0;
         phase_in = PH_WR_LOW;
         timer_in = wr_byte[0] ? load_ticks({2'b0, cfg.slot_short_ticks})
                               : load_ticks({2'b0, cfg.slot_long_ticks});
      end
      if (start_rd) begin
         shift_in = 8'd0;
         bit_in   = 3'd0;
         phase_in = PH_RD_LOW;
         timer_in = load_ticks({2'b0, cfg.slot_short_ticks});
      end
      if (do_finish) begin
         phase_in  = PH_IDLE;
         timer_in  = '0;
         active_in = 3'd0;
         seq_in    = 3'd0;
         ev        = fin_ev;
         st        = fin_st;
      end
   end

   always_comb begin
      rsp.drive_low  = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW)
                       || (phase_in == PH_RD_LOW);
      rsp.drive_high = (phase_in == PH_IDLE) && spu_in;
      rsp.event_res  = ev;
      rsp.status     = st;
      rsp.read_data  = rdat;
      rsp.last       = rlast;
      rsp.busy_res   = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         timer_ff  <= '0;
         bit_ff    <= 3'd0;
         shift_ff  <= 8'd0;
         bcount_ff <= 4'd0;
         seq_ff    <= 3'd0;
         active_ff <= 3'd0;
         spu_ff    <= 1'b0;
      end else if (cmd_take) begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         bcount_ff <= bcount_in;
         seq_ff    <= seq_in;
         active_ff <= active_in;
         spu_ff    <= spu_in;
      end
   end

endmodule

@@ design/owm_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// owm_rsp_queue
// short queue holding result words until they are popped
// ----------------------------------------------------------------------------
module owm_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  owm_pkg::owm_rsp_type wr_word,
   output logic                 q_full,
   input  logic                 pop,
   output logic                 empty,
   output owm_pkg::owm_rsp_type rd_word
);
   import owm_pkg::*;

   owm_rsp_type entry_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop_ok;

   assign q_full  = (count_ff == 2'(QUEUE_DEPTH));
   assign empty   = (count_ff == 2'd0);
   assign pop_ok  = pop && !empty;
   assign rd_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + 2'(wr_en) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/onewire_bus_master_unit.sv @@
// ----------------------------------------------------------------------------
// onewire_bus_master_unit
// single-wire bus master driven by one-microsecond tick words
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. Tick words advance bus
// time by one microsecond; command words start a bus reset, a byte write or
// read, the convert or scratchpad sequences, or switch the strong pull-up.
// Throughput is one word per clock while the result queue has room: the front
// end takes a word into a two-entry queue, the engine retires one queued word
// per clock in a single state machine step, and its result enters a two-entry
// result queue. A pushed word is registered in the front queue, and its result
// is registered in the result queue when the engine takes the word, from where
// it shows on the rsp_ ports and can be popped.
// full rises only when both queues back up behind pop.
// Timing registers may be written only while no word is in flight.
// ----------------------------------------------------------------------------
module onewire_bus_master_unit (
   input  logic       clock,
   input  logic       reset,
   // input words
   input  logic       push,
   output logic       full,
   input  logic [2:0] req_op,
   input  logic [7:0] req_data,
   input  logic       req_line_level,
   // result words
   output logic       empty,
   input  logic       pop,
   output logic       rsp_drive_low,
   output logic       rsp_drive_high,
   output logic [1:0] rsp_event_res,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_read_data,
   output logic       rsp_last,
   output logic       rsp_busy_res,
   // timing registers
   input  logic       csr_we,
   input  logic [2:0] csr_addr,
   input  logic [9:0] csr_wdata
);
   import owm_pkg::*;

   owm_cfg_type cfg_ff, cfg_in;
   logic        cmd_valid;
   owm_cmd_type cmd;
   logic        cmd_take;
   logic        rsp_q_full;
   owm_rsp_type eng_rsp;
   owm_rsp_type out_word;

   // timing register file, writes outside the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_RESET_LOW:  cfg_in.reset_low_ticks      = csr_wdata;
            REG_PRES_WAIT:  cfg_in.presence_wait_ticks  = csr_wdata;
            REG_RESET_REC:  cfg_in.reset_recovery_ticks = csr_wdata;
            REG_SLOT_SHORT: cfg_in.slot_short_ticks     = csr_wdata[7:0];
            REG_SLOT_LONG:  cfg_in.slot_long_ticks      = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks      <= 10'd500;
         cfg_ff.presence_wait_ticks  <= 10'd70;
         cfg_ff.reset_recovery_ticks <= 10'd500;
         cfg_ff.slot_short_ticks     <= 8'd7;
         cfg_ff.slot_long_ticks      <= 8'd70;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: classify and queue input words
   owm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .op         (req_op),
      .data       (req_data),
      .line_level (req_line_level),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take)
   );

   // engine: one state machine step per queued word
   owm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_full  (rsp_q_full),
      .rsp       (eng_rsp)
   );

   // result queue toward the consumer
   owm_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_take),
      .wr_word (eng_rsp),
      .q_full  (rsp_q_full),
      .pop     (pop),
      .empty   (empty),
      .rd_word (out_word)
   );

   assign rsp_drive_low  = out_word.drive_low;
   assign rsp_drive_high = out_word.drive_high;
   assign rsp_event_res  = out_word.event_res;
   assign rsp_status     = out_word.status;
   assign rsp_read_data  = out_word.read_data;
   assign rsp_last       = out_word.last;
   assign rsp_busy_res   = out_word.busy_res;

   // engine never writes into a full result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> !rsp_q_full)
      else $error("result queue overflow");

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (empty && !full))
      else $error("queues not empty after reset");

   // the line is never pulled low and driven high at once
   a_drive_excl: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_drive_low && rsp_drive_high))
      else $error("conflicting line drive");

   // a last marker only travels with a read byte that ends the run
   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last) |-> (rsp_event_res == EV_BYTE && !rsp_busy_res))
      else $error("last marker without final read byte");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the single-wire bus master unit
// ----------------------------------------------------------------------------
// A table of directed words runs first: idle ticks, the unused code, the
// pull-up, a reset into a line held low, and commands rejected while busy.
// It then runs every operation at minimum timing and a sequence with all
// lengths set to zero.
// Random operations follow, with random content under small timing settings.
// Every accepted word goes through a bit-level predictor of the bus master.
// The result words are compared field by field, in order, with its output.
// ----------------------------------------------------------------------------
module tb;
   import owm_pkg::*;

   localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
   localparam int DRAIN_CYCLES = 10;    // settle time after the last result
   localparam int IDLE_PCT     = 22;
   localparam int RAND_PHASES  = 5;
   localparam int PHASE_WORDS  = 24;

   // sequence steps of convert / scratchpad runs
   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_SKIP = 3'd1;
   localparam logic [2:0] SEQ_FUNC = 3'd2;
   localparam logic [2:0] SEQ_READ = 3'd3;

   typedef enum logic [3:0] {
      BP_IDLE, BP_RST_LOW, BP_RST_WAIT, BP_RST_REC,
      BP_WR_LOW, BP_WR_REL, BP_RD_LOW, BP_RD_WAIT, BP_RD_REC
   } bus_phase_type;

   typedef struct packed {
      bit          is_cfg;
      owm_cfg_type cfg;
      logic [2:0]  op;
      logic [7:0]  data;
      logic        line;
      logic [15:0] reps;    // zero: tick until the bus goes idle
      bit          typed;
      owm_rsp_type rsp;
   } stim_row_type;

   // dut ports
   logic       clock;
   logic       reset          = 1'b1;
   logic       push           = 1'b0;
   logic       full;
   logic [2:0] req_op         = OP_TICK;
   logic [7:0] req_data       = 8'h00;
   logic       req_line_level = 1'b1;
   logic       empty;
   logic       pop            = 1'b0;
   logic       rsp_drive_low;
   logic       rsp_drive_high;
   logic [1:0] rsp_event_res;
   logic [1:0] rsp_status;
   logic [7:0] rsp_read_data;
   logic       rsp_last;
   logic       rsp_busy_res;
   logic       csr_we         = 1'b0;
   logic [2:0] csr_addr       = REG_RESET_LOW;
   logic [9:0] csr_wdata      = 10'd0;

   // predictor state: timing copy, bus phase and shift machinery
   owm_cfg_type   tcfg;
   bus_phase_type bp;
   logic [9:0]    slot_timer;
   logic [2:0]    bit_idx;
   logic [7:0]    shreg;
   logic [3:0]    byte_cnt;
   logic [2:0]    seq_step;
   logic [2:0]    cur_cmd;
   logic          spu_on;
   // result of the word being predicted
   logic [1:0]    w_ev;
   logic [1:0]    w_st;
   logic [7:0]    w_data;
   logic          w_last;

   owm_rsp_type  pending_rsp[$];   // result words still owed by the dut
   stim_row_type stim_table[$];
   bit           calm = 1'b0;      // no idling on either side while set
   int           n_fail     = 0;
   int           n_words    = 0;
   int           n_results  = 0;
   int           n_bytes    = 0;
   int           n_rejected = 0;
   int           n_settings = 0;
   int           stall_cnt  = 0;

   onewire_bus_master_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_op         (req_op),
      .req_data       (req_data),
      .req_line_level (req_line_level),
      .empty          (empty),
      .pop            (pop),
      .rsp_drive_low  (rsp_drive_low),
      .rsp_drive_high (rsp_drive_high),
      .rsp_event_res  (rsp_event_res),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .rsp_last       (rsp_last),
      .rsp_busy_res   (rsp_busy_res),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // load a phase timer; a zero length still lasts one tick
   function automatic void phase_load(bus_phase_type ph, logic [9:0] ticks);
      bp = ph;
      slot_timer = (ticks == 10'd0) ? 10'd1 : ticks;
   endfunction

   function automatic void op_done(logic [1:0] ev, logic [1:0] st);
      bp = BP_IDLE;
      slot_timer = 10'd0;
      cur_cmd = OP_TICK;
      seq_step = SEQ_NONE;
      w_ev = ev;
      w_st = st;
   endfunction

   // a one bit gets the short low pulse, a zero bit the long one
   function automatic void write_start(logic [7:0] b);
      shreg = b;
      bit_idx = 3'd0;
      phase_load(BP_WR_LOW, shreg[0] ? {2'b00, tcfg.slot_short_ticks}
                                     : {2'b00, tcfg.slot_long_ticks});
   endfunction

   function automatic void read_start();
      shreg = 8'h00;
      bit_idx = 3'd0;
      phase_load(BP_RD_LOW, {2'b00, tcfg.slot_short_ticks});
   endfunction

   // after a written byte a sequence moves on to its next step
   function automatic void byte_written();
      if (cur_cmd == OP_CONVERT || cur_cmd == OP_SCRATCH) begin
         if (seq_step == SEQ_SKIP) begin
            seq_step = SEQ_FUNC;
            write_start(cur_cmd == OP_CONVERT ? CMD_CONVERT : CMD_READ_SP);
            return;
         end
         if (cur_cmd == OP_SCRATCH) begin
            seq_step = SEQ_READ;
            byte_cnt = 4'd0;
            read_start();
            return;
         end
      end
      op_done(EV_DONE, ST_OK);
   endfunction

   // scratchpad bytes come out one by one, only the final one is marked
   function automatic void byte_read();
      logic [7:0] b;
      b = shreg;
      if (cur_cmd == OP_SCRATCH) begin
         byte_cnt = byte_cnt + 4'd1;
         if (byte_cnt < SCRATCH_BYTES) begin
            read_start();
            w_ev = EV_BYTE;
            w_data = b;
            return;
         end
      end
      op_done(EV_BYTE, ST_OK);
      w_data = b;
      w_last = 1'b1;
   endfunction

   // one microsecond of bus time
   function automatic void tick_advance(logic line);
      if (slot_timer != 10'd0) slot_timer = slot_timer - 10'd1;
      if (slot_timer != 10'd0) return;
      case (bp)
         BP_RST_LOW: phase_load(BP_RST_WAIT, tcfg.presence_wait_ticks);
         BP_RST_WAIT: begin
            // presence pulse: line low means a device answered
            shreg = line ? 8'h00 : 8'h01;
            phase_load(BP_RST_REC, tcfg.reset_recovery_ticks);
         end
         BP_RST_REC: begin
            if (!shreg[0]) op_done(EV_DONE, ST_NO_DEV);
            else if (cur_cmd == OP_RESET) op_done(EV_DONE, ST_OK);
            else begin
               seq_step = SEQ_SKIP;
               write_start(CMD_SKIP_ROM);
            end
         end
         BP_WR_LOW: phase_load(BP_WR_REL, shreg[0] ? {2'b00, tcfg.slot_long_ticks}
                                                   : {2'b00, tcfg.slot_short_ticks});
         BP_WR_REL: begin
            shreg = shreg >> 1;
            if (bit_idx >= 3'd7) byte_written();
            else begin
               bit_idx = bit_idx + 3'd1;
               phase_load(BP_WR_LOW, shreg[0] ? {2'b00, tcfg.slot_short_ticks}
                                              : {2'b00, tcfg.slot_long_ticks});
            end
         end
         BP_RD_LOW: phase_load(BP_RD_WAIT, {2'b00, tcfg.slot_short_ticks});
         BP_RD_WAIT: begin
            shreg = {line, shreg[7:1]};
            phase_load(BP_RD_REC, {2'b00, tcfg.slot_long_ticks});
         end
         BP_RD_REC: begin
            if (bit_idx >= 3'd7) byte_read();
            else begin
               bit_idx = bit_idx + 3'd1;
               phase_load(BP_RD_LOW, {2'b00, tcfg.slot_short_ticks});
            end
         end
         default: op_done(EV_NONE, ST_OK);
      endcase
   endfunction

   // expected result word of one input word, advancing the predictor state
   function automatic owm_rsp_type bus_master_next(logic [2:0] op, logic [7:0] d,
                                                   logic line);
      owm_rsp_type r;
      w_ev = EV_NONE;
      w_st = ST_OK;
      w_data = 8'h00;
      w_last = 1'b0;
      if (op != OP_UNUSED) begin
         if (bp != BP_IDLE) begin
            if (op == OP_TICK) tick_advance(line);
            else w_st = ST_BUSY;
         end else if (op == OP_PULLUP) begin
            spu_on = d[0];
            w_ev = EV_DONE;
         end else if (op != OP_TICK) begin
            // any bus command drops the strong pull-up
            spu_on = 1'b0;
            cur_cmd = op;
            seq_step = SEQ_NONE;
            if (op == OP_WRITE) write_start(d);
            else if (op == OP_READ) read_start();
            else if (!line) op_done(EV_DONE, ST_NO_DEV);
            else phase_load(BP_RST_LOW, tcfg.reset_low_ticks);
         end
      end
      r.drive_low  = (bp == BP_RST_LOW) || (bp == BP_WR_LOW) || (bp == BP_RD_LOW);
      r.drive_high = (bp == BP_IDLE) && spu_on;
      r.event_res  = w_ev;
      r.status     = w_st;
      r.read_data  = w_data;
      r.last       = w_last;
      r.busy_res   = (bp != BP_IDLE);
      return r;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic owm_rsp_type rsp_word(logic dl, logic dh, logic [1:0] ev,
                                            logic [1:0] st, logic busy);
      owm_rsp_type r;
      r.drive_low  = dl;
      r.drive_high = dh;
      r.event_res  = ev;
      r.status     = st;
      r.read_data  = 8'h00;
      r.last       = 1'b0;
      r.busy_res   = busy;
      return r;
   endfunction

   function automatic owm_cfg_type timing(int rl, int pw, int rr, int ss, int sl);
      owm_cfg_type c;
      c.reset_low_ticks      = 10'(rl);
      c.presence_wait_ticks  = 10'(pw);
      c.reset_recovery_ticks = 10'(rr);
      c.slot_short_ticks     = 8'(ss);
      c.slot_long_ticks      = 8'(sl);
      return c;
   endfunction

   function automatic void add_row(logic [2:0] op, logic [7:0] d, logic line,
                                   int reps, bit typed, owm_rsp_type r);
      stim_row_type s;
      s = '0;
      s.op    = op;
      s.data  = d;
      s.line  = line;
      s.reps  = 16'(reps);
      s.typed = typed;
      s.rsp   = r;
      stim_table.push_back(s);
   endfunction

   function automatic void add_cfg(owm_cfg_type c);
      stim_row_type s;
      s = '0;
      s.is_cfg = 1'b1;
      s.cfg    = c;
      stim_table.push_back(s);
   endfunction

   // mostly present devices during the presence window, random bits otherwise
   function automatic logic pick_line();
      if (bp == BP_RST_WAIT) return ($urandom_range(99) < 85) ? 1'b0 : 1'b1;
      return 1'($urandom_range(1));
   endfunction

   // offer one word, wait for the handshake, then log what it must produce
   task automatic send_word(input logic [2:0] op, input logic [7:0] d, input logic line,
                            input bit typed, input owm_rsp_type typed_rsp);
      owm_rsp_type p;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_op         <= op;
      req_data       <= d;
      req_line_level <= line;
      @(posedge clock);
      while (full) @(posedge clock);
      p = bus_master_next(op, d, line);
      pending_rsp.push_back(typed ? typed_rsp : p);
      if (op != OP_UNUSED) n_words++;
      if (p.status == ST_BUSY) n_rejected++;
      if (p.event_res == EV_BYTE) n_bytes++;
   endtask

   task automatic tick_until_idle(input bit rand_line, input logic line);
      while (bp != BP_IDLE)
         send_word(OP_TICK, 8'($urandom), rand_line ? pick_line() : line, 1'b0, '0);
   endtask

   // timing registers change only once every word in flight has come back
   task automatic load_timing(input owm_cfg_type c);
      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_RESET_LOW;
      csr_wdata <= c.reset_low_ticks;
      @(posedge clock);
      csr_addr  <= REG_PRES_WAIT;
      csr_wdata <= c.presence_wait_ticks;
      @(posedge clock);
      csr_addr  <= REG_RESET_REC;
      csr_wdata <= c.reset_recovery_ticks;
      @(posedge clock);
      csr_addr  <= REG_SLOT_SHORT;
      csr_wdata <= {2'b00, c.slot_short_ticks};
      @(posedge clock);
      csr_addr  <= REG_SLOT_LONG;
      csr_wdata <= {2'b00, c.slot_long_ticks};
      @(posedge clock);
      csr_we <= 1'b0;
      tcfg = c;
      n_settings++;
   endtask

   task automatic check_field(input string name, input logic [7:0] expv,
                              input logic [7:0] actv);
      if (actv !== expv) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
         n_fail++;
      end
   endtask

   // ---------------------------------------------------------------- result side

   // pop stalls at random except in the calm stretch; each popped word is
   // matched against the oldest expectation
   always @(posedge clock) begin
      owm_rsp_type e;
      pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!reset && pop && !empty) begin
         n_results++;
         if (pending_rsp.size() == 0) begin
            $error("result word popped with nothing expected");
            n_fail++;
         end else begin
            e = pending_rsp.pop_front();
            check_field("drive_low",  8'(e.drive_low),  8'(rsp_drive_low));
            check_field("drive_high", 8'(e.drive_high), 8'(rsp_drive_high));
            check_field("event_res",  8'(e.event_res),  8'(rsp_event_res));
            check_field("status",     8'(e.status),     8'(rsp_status));
            check_field("read_data",  e.read_data,      rsp_read_data);
            check_field("last",       8'(e.last),       8'(rsp_last));
            check_field("busy_res",   8'(e.busy_res),   8'(rsp_busy_res));
         end
      end
   end

   // watchdog: too long without a word moving on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) stall_cnt <= 0;
      else if (stall_cnt >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else stall_cnt <= stall_cnt + 1;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      stim_row_type row;
      owm_cfg_type  c;
      logic [2:0]   op;
      int           pick;
      int           budget;

      // predictor after reset: default timing, bus idle, pull-up off
      tcfg       = timing(500, 70, 500, 7, 70);
      bp         = BP_IDLE;
      slot_timer = 10'd0;
      bit_idx    = 3'd0;
      shreg      = 8'h00;
      byte_cnt   = 4'd0;
      seq_step   = SEQ_NONE;
      cur_cmd    = OP_TICK;
      spu_on     = 1'b0;

      // directed table, default timing first
      add_row(OP_TICK,    8'h00, 1'b1, 1, 1'b1,
              rsp_word(1'b0, 1'b0, EV_NONE, ST_OK, 1'b0));
      add_row(OP_UNUSED,  8'hFF, 1'b0, 1, 1'b1,
              rsp_word(1'b0, 1'b0, EV_NONE, ST_OK, 1'b0));
      add_row(OP_PULLUP,  8'h01, 1'b1, 1, 1'b1,
              rsp_word(1'b0, 1'b1, EV_DONE, ST_OK, 1'b0));
      add_row(OP_TICK,    8'h00, 1'b1, 1, 1'b1,
              rsp_word(1'b0, 1'b1, EV_NONE, ST_OK, 1'b0));
      // line held low at reset start, which also drops the pull-up
      add_row(OP_RESET,   8'h00, 1'b0, 1, 1'b1,
              rsp_word(1'b0, 1'b0, EV_DONE, ST_NO_DEV, 1'b0));
      add_row(OP_PULLUP,  8'hFF, 1'b1, 1, 1'b1,
              rsp_word(1'b0, 1'b1, EV_DONE, ST_OK, 1'b0));
      // minimum timing from here on keeps bus operations short
      add_cfg(timing(1, 1, 1, 1, 1));
      add_row(OP_RESET,   8'h00, 1'b1, 1, 1'b1,
              rsp_word(1'b1, 1'b0, EV_NONE, ST_OK, 1'b1));
      // commands while busy are rejected, the unused code is ignored
      add_row(OP_WRITE,   8'hA5, 1'b1, 1, 1'b1,
              rsp_word(1'b1, 1'b0, EV_NONE, ST_BUSY, 1'b1));
      add_row(OP_PULLUP,  8'h01, 1'b1, 1, 1'b1,
              rsp_word(1'b1, 1'b0, EV_NONE, ST_BUSY, 1'b1));
      add_row(OP_UNUSED,  8'h00, 1'b1, 1, 1'b1,
              rsp_word(1'b1, 1'b0, EV_NONE, ST_OK, 1'b1));
      add_row(OP_TICK,    8'h00, 1'b0, 0, 1'b0, '0);
      // byte extremes, reads, busy rejections of reset, convert, scratchpad and read
      add_row(OP_WRITE,   8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_TICK,    8'h00, 1'b0, 0, 1'b0, '0);
      add_row(OP_WRITE,   8'hFF, 1'b0, 1, 1'b0, '0);
      add_row(OP_TICK,    8'h00, 1'b1, 0, 1'b0, '0);
      add_row(OP_READ,    8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_TICK,    8'h00, 1'b1, 0, 1'b0, '0);
      add_row(OP_READ,    8'hFF, 1'b0, 1, 1'b0, '0);
      add_row(OP_RESET,   8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_CONVERT, 8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_SCRATCH, 8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_READ,    8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_TICK,    8'h00, 1'b0, 0, 1'b0, '0);
      // convert with no presence pulse, then a full scratchpad run
      add_row(OP_CONVERT, 8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_TICK,    8'h00, 1'b1, 0, 1'b0, '0);
      add_row(OP_SCRATCH, 8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_TICK,    8'h00, 1'b0, 0, 1'b0, '0);
      add_row(OP_PULLUP,  8'hFE, 1'b1, 1, 1'b1,
              rsp_word(1'b0, 1'b0, EV_DONE, ST_OK, 1'b0));
      // zero lengths count as one tick
      add_cfg(timing(0, 0, 0, 0, 0));
      add_row(OP_CONVERT, 8'h00, 1'b1, 1, 1'b0, '0);
      add_row(OP_TICK,    8'h00, 1'b0, 0, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.is_cfg) load_timing(row.cfg);
         else if (row.reps == 16'd0) tick_until_idle(1'b0, row.line);
         else repeat (row.reps) send_word(row.op, row.data, row.line, row.typed, row.rsp);
      end

      // random operations under small timing; one phase runs without idling
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == 3) c = timing($urandom_range(20, 1), $urandom_range(20, 1),
                                 $urandom_range(20, 1), $urandom_range(6, 1),
                                 $urandom_range(6, 1));
         else c = timing($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1),
                         $urandom_range(3, 1), $urandom_range(3, 1));
         load_timing(c);
         calm = (ph == 2);
         budget = n_words + PHASE_WORDS;
         while (n_words < budget) begin
            pick = $urandom_range(99);
            if (pick < 15) op = OP_RESET;
            else if (pick < 33) op = OP_WRITE;
            else if (pick < 51) op = OP_READ;
            else if (pick < 63) op = OP_CONVERT;
            else if (pick < 69) op = OP_SCRATCH;
            else if (pick < 79) op = OP_PULLUP;
            else if (pick < 84) op = OP_UNUSED;
            else op = OP_TICK;
            // the line is usually released when a reset starts
            send_word(op, 8'($urandom), ($urandom_range(99) < 92), 1'b0, '0);
            while (bp != BP_IDLE) begin
               if ($urandom_range(99) < 6)
                  send_word(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom_range(1)),
                            1'b0, '0);
               else send_word(OP_TICK, 8'($urandom), pick_line(), 1'b0, '0);
            end
         end
      end
      calm = 1'b0;

      // drain the result side, then wait out the settle time for stray words
      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input words and %0d result words, %0d bytes read back",
               n_words, n_results, n_bytes);
      $display("%0d busy rejections across %0d timing settings", n_rejected, n_settings);
      if (n_fail == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

@@ onewire_bus_master_unit.f @@
design/owm_pkg.sv
design/owm_front.sv
design/owm_engine.sv
design/owm_rsp_queue.sv
design/onewire_bus_master_unit.sv
tb/tb.sv
